@@ src/stt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and character classes of the shell command tokenizer.
package stt_pkg;

  // Result codes
  localparam logic [2:0] EV_BEGIN = 3'd0;
  localparam logic [2:0] EV_CHAR  = 3'd1;
  localparam logic [2:0] EV_END   = 3'd2;
  localparam logic [2:0] EV_CMD   = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  localparam logic [1:0] K_WORD = 2'd0;
  localparam logic [1:0] K_NUM  = 2'd1;
  localparam logic [1:0] K_STR  = 2'd2;
  localparam logic [1:0] K_SYM  = 2'd3;

  localparam logic [2:0] ERR_BAD_CHAR   = 3'd0;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd1;
  localparam logic [2:0] ERR_UNSUPP     = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd3;
  localparam logic [2:0] ERR_EMPTY      = 3'd4;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_MARK0  = 8'hEF;
  localparam logic [7:0] CH_MARK1  = 8'hBB;
  localparam logic [7:0] CH_MARK2  = 8'hBF;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h00;

  // At most five results follow from one byte.
  localparam int MAX_RES = 5;
  localparam int STT_QUEUE_DEPTH = 4;

  typedef enum logic [9:0] {
    M_MARK0 = 10'b00_0000_0001,
    M_MARK1 = 10'b00_0000_0010,
    M_MARK2 = 10'b00_0000_0100,
    M_IDLE  = 10'b00_0000_1000,
    M_WORD  = 10'b00_0001_0000,
    M_NUM   = 10'b00_0010_0000,
    M_MINUS = 10'b00_0100_0000,
    M_STR   = 10'b00_1000_0000,
    M_ESC   = 10'b01_0000_0000,
    M_DROP  = 10'b10_0000_0000
  } scan_mode_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] err;
  } res_t;

  typedef struct packed {
    logic [2:0]               count;
    res_t [MAX_RES-1:0]       res;
  } bundle_t;

  function automatic res_t mk_res(input logic [2:0] ev, input logic [1:0] kind,
                                  input logic [7:0] ch, input logic [2:0] err);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.ch   = ch;
    r.err  = err;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic word_start(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h24};
  endfunction

  function automatic logic word_cont(input logic [7:0] c);
    return word_start(c) || is_digit(c);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c inside {8'h2E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3A, 8'h3B};
  endfunction

endpackage

@@ src/stt_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for command bytes in and token events out.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_command;

  modport source (output valid, output char_byte, output end_of_command, input ready);
  modport sink   (input valid, input char_byte, input end_of_command, output ready);
endinterface

interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [1:0] token_kind;
  logic [7:0] token_char;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output event_res, output token_kind, output token_char,
                  output error_code, output last_of_run, input ready);
  modport sink   (input valid, input event_res, input token_kind, input token_char,
                  input error_code, input last_of_run, output ready);
endinterface

@@ src/stt_front.sv @@
`timescale 1ns / 1ps
// Front end: scanner state machine that turns one byte into a bundle of results.
module stt_front
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  stt_in_if.sink   in_chan,
  output logic     push_valid,
  output bundle_t  push_data,
  input  logic     queue_full
);

  scan_mode_t mode_r, mode_nxt;
  logic       dq_r, dq_nxt;
  logic       seen_r, seen_nxt;

  logic       in_fire;
  logic [7:0] c;
  logic       last;
  logic [2:0] n;
  logic       do_idle;
  logic [7:0] quote;
  logic [7:0] esc_ch;
  logic       esc_ok;
  bundle_t    bundle;

  assign in_chan.ready = !queue_full;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign c             = in_chan.char_byte;
  assign last          = in_chan.end_of_command;
  assign quote         = dq_r ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    esc_ok = 1'b1;
    case (c)
      CH_LOW_N:  esc_ch = CH_LF;
      CH_LOW_R:  esc_ch = CH_CR;
      CH_LOW_T:  esc_ch = CH_TAB;
      CH_BSLASH: esc_ch = CH_BSLASH;
      CH_SQUOTE: esc_ch = CH_SQUOTE;
      CH_DQUOTE: esc_ch = CH_DQUOTE;
      default: begin
        esc_ch = CH_ZERO;
        esc_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    dq_nxt   = dq_r;
    seen_nxt = seen_r;
    bundle   = '0;
    n        = 3'd0;
    do_idle  = 1'b0;

    case (mode_r)
      M_MARK0: begin
        if (c == CH_MARK0) mode_nxt = M_MARK1;
        else do_idle = 1'b1;
      end
      M_MARK1: begin
        if (c == CH_MARK1) begin
          mode_nxt = M_MARK2;
        end else begin
          bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          mode_nxt = M_DROP;
        end
      end
      M_MARK2: begin
        if (c == CH_MARK2) begin
          mode_nxt = M_IDLE;
        end else begin
          bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          mode_nxt = M_DROP;
        end
      end
      M_IDLE: do_idle = 1'b1;
      M_WORD: begin
        if (word_cont(c)) begin
          bundle.res[n] = mk_res(EV_CHAR, K_WORD, c, ERR_BAD_CHAR); n = n + 3'd1;
        end else begin
          bundle.res[n] = mk_res(EV_END, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          bundle.res[n] = mk_res(EV_CHAR, K_NUM, c, ERR_BAD_CHAR); n = n + 3'd1;
        end else begin
          bundle.res[n] = mk_res(EV_END, K_NUM, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          do_idle = 1'b1;
        end
      end
      M_MINUS: begin
        if (is_digit(c)) begin
          seen_nxt = 1'b1;
          bundle.res[n] = mk_res(EV_BEGIN, K_NUM, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          bundle.res[n] = mk_res(EV_CHAR, K_NUM, CH_MINUS, ERR_BAD_CHAR); n = n + 3'd1;
          bundle.res[n] = mk_res(EV_CHAR, K_NUM, c, ERR_BAD_CHAR); n = n + 3'd1;
          mode_nxt = M_NUM;
        end else begin
          bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          mode_nxt = M_DROP;
        end
      end
      M_STR: begin
        if (c == quote) begin
          bundle.res[n] = mk_res(EV_END, K_STR, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          mode_nxt = M_IDLE;
        end else if (c == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else begin
          bundle.res[n] = mk_res(EV_CHAR, K_STR, c, ERR_BAD_CHAR); n = n + 3'd1;
        end
      end
      M_ESC: begin
        if (esc_ok) begin
          bundle.res[n] = mk_res(EV_CHAR, K_STR, esc_ch, ERR_BAD_CHAR); n = n + 3'd1;
          mode_nxt = M_STR;
        end else begin
          bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_UNSUPP); n = n + 3'd1;
          mode_nxt = M_DROP;
        end
      end
      default: mode_nxt = M_DROP;
    endcase

    // Byte seen between tokens
    if (do_idle) begin
      mode_nxt = M_IDLE;
      if (is_space(c)) begin
        mode_nxt = M_IDLE;
      end else if (word_start(c)) begin
        seen_nxt = 1'b1;
        bundle.res[n] = mk_res(EV_BEGIN, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
        bundle.res[n] = mk_res(EV_CHAR, K_WORD, c, ERR_BAD_CHAR); n = n + 3'd1;
        mode_nxt = M_WORD;
      end else if (is_digit(c)) begin
        seen_nxt = 1'b1;
        bundle.res[n] = mk_res(EV_BEGIN, K_NUM, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
        bundle.res[n] = mk_res(EV_CHAR, K_NUM, c, ERR_BAD_CHAR); n = n + 3'd1;
        mode_nxt = M_NUM;
      end else if (c == CH_MINUS) begin
        mode_nxt = M_MINUS;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        seen_nxt = 1'b1;
        dq_nxt   = (c == CH_DQUOTE);
        bundle.res[n] = mk_res(EV_BEGIN, K_STR, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
        mode_nxt = M_STR;
      end else if (is_symbol(c)) begin
        seen_nxt = 1'b1;
        bundle.res[n] = mk_res(EV_BEGIN, K_SYM, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
        bundle.res[n] = mk_res(EV_CHAR, K_SYM, c, ERR_BAD_CHAR); n = n + 3'd1;
        bundle.res[n] = mk_res(EV_END, K_SYM, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
      end else begin
        bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
        mode_nxt = M_DROP;
      end
    end

    // Close the command on its final byte
    if (last) begin
      if (mode_nxt != M_DROP) begin
        case (mode_nxt)
          M_WORD: begin
            bundle.res[n] = mk_res(EV_END, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
            mode_nxt = M_IDLE;
          end
          M_NUM: begin
            bundle.res[n] = mk_res(EV_END, K_NUM, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
            mode_nxt = M_IDLE;
          end
          M_STR: begin
            bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_UNCLOSED); n = n + 3'd1;
            mode_nxt = M_DROP;
          end
          M_ESC: begin
            bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_INCOMPLETE); n = n + 3'd1;
            mode_nxt = M_DROP;
          end
          M_IDLE: mode_nxt = M_IDLE;
          default: begin
            bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
            mode_nxt = M_DROP;
          end
        endcase
        if (mode_nxt == M_IDLE) begin
          if (seen_nxt) begin
            bundle.res[n] = mk_res(EV_CMD, K_WORD, CH_ZERO, ERR_BAD_CHAR); n = n + 3'd1;
          end else begin
            bundle.res[n] = mk_res(EV_ERR, K_WORD, CH_ZERO, ERR_EMPTY); n = n + 3'd1;
          end
        end
      end
      mode_nxt = M_MARK0;
      dq_nxt   = 1'b0;
      seen_nxt = 1'b0;
    end

    bundle.count = n;
  end

  assign push_valid = in_fire && (n != 3'd0);
  assign push_data  = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_MARK0;
      dq_r   <= 1'b0;
      seen_r <= 1'b0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
      seen_r <= seen_nxt;
    end
  end

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last |=> mode_r == M_MARK0 && !seen_r && !dq_r)
    else $error("final byte did not rearm the scanner");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_r == M_DROP |-> !push_valid)
    else $error("results produced while dropping after an error");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_data.count <= 3'(MAX_RES))
    else $error("bundle holds more results than one byte can cause");

endmodule

@@ src/stt_queue.sv @@
`timescale 1ns / 1ps
// Small bundle queue between the scanner and the result sequencer.
module stt_queue
  import stt_pkg::*;
#(
  parameter int DEPTH = STT_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output bundle_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ src/stt_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the head bundle to an output register, a result a cycle unless stalled.
module stt_back
  import stt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  bundle_t  q_head,
  output logic     q_pop,
  stt_out_if.source out_chan
);

  logic       out_valid_r;
  res_t       out_res_r;
  logic       out_last_r;
  logic [2:0] idx_r, idx_nxt;
  logic       load;
  logic       at_end;

  assign load    = !out_valid_r || out_chan.ready;
  assign at_end  = (idx_r == q_head.count - 3'd1);
  assign q_pop   = load && q_valid && at_end;
  assign idx_nxt = at_end ? 3'd0 : idx_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_res_r  <= q_head.res[idx_r];
      out_last_r <= at_end;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_res   = out_res_r.ev;
  assign out_chan.token_kind  = out_res_r.kind;
  assign out_chan.token_char  = out_res_r.ch;
  assign out_chan.error_code  = out_res_r.err;
  assign out_chan.last_of_run = out_last_r;

  a_bundle_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> q_valid)
    else $error("bundle left the queue before all its results were sent");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> idx_r < q_head.count)
    else $error("result index ran past the bundle size");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r && out_last_r)
    else $error("bundle retired without flagging its final result");

endmodule

@@ src/shell_command_tokenizer_core.sv @@
`timescale 1ns / 1ps
// Top level of the shell command tokenizer: scanner, bundle queue and result sequencer.
// Path: the results of a byte are written into the bundle queue, then into the output register.
// Throughput: one byte a cycle while the queue has room; results leave one a cycle while the
// sink is ready, and the output sequencer spells out all results of a byte (at most five).
// Reset: synchronous, active low; the scanner rearms to the start of a command and the queue
// and output register empty.
module shell_command_tokenizer_core
  import stt_pkg::*;
#(
  parameter int QUEUE_DEPTH = STT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);

  // The front end classifies each byte and resolves all of its results in the
  // cycle of its transaction, packing them into a bundle with a count. Bytes
  // that cause nothing (spaces, the mark, bytes dropped after an error) leave
  // no trace in the queue.
  logic    push_valid;
  bundle_t push_data;
  logic    queue_full;

  // The queue decouples the two halves: the scanner keeps taking bytes while
  // the back end is still spelling out a long bundle or the sink stalls.
  logic    q_valid;
  logic    q_pop;
  bundle_t q_head;

  stt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // The back end reads the head bundle one result at a time into its output
  // register and retires the bundle with its final result, which carries the
  // last_of_run flag.
  stt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

@@ tb/tb_shell_command_tokenizer_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the shell command tokenizer core: byte stimulus and event checks.
module tb_shell_command_tokenizer_core;
  import stt_pkg::*;

  localparam int IDLE_PCT        = 23;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_ITEMS    = 250;
  localparam int TIMEOUT_NS      = 2_000_000;

  // One token event as seen on the result channel.
  typedef struct packed {
    logic [2:0] ev;
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] err;
    logic       last;
  } token_event_t;

  // Follows the scanner byte by byte and keeps the events still owed by the block.
  // note_byte works out the events of an accepted byte; check_event matches one
  // event from the output against the oldest of them.
  class token_event_tracker;
    localparam logic [1:0] NO_KIND = 2'd0;
    localparam logic [2:0] NO_ERR  = 3'd0;

    scan_mode_t   mode;
    bit           dquote;
    bit           any_token;
    token_event_t waiting[$];
    token_event_t burst[$];
    int           failures;

    function new();
      mode      = M_MARK0;
      dquote    = 1'b0;
      any_token = 1'b0;
      failures  = 0;
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function bit digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit word_head(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function bit word_tail(logic [7:0] c);
      return word_head(c) || digit_ch(c);
    endfunction

    function bit blank_ch(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit symbol_ch(logic [7:0] c);
      case (c)
        ".", "(", ")", "{", "}", "[", "]", ",", ":", ";": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void put(logic [2:0] ev, logic [1:0] kind, logic [7:0] ch, logic [2:0] err);
      token_event_t e;
      e.ev   = ev;
      e.kind = kind;
      e.ch   = ch;
      e.err  = err;
      e.last = 1'b0;
      if (burst.size() < MAX_RES) burst.insert(burst.size(), e);
    endfunction

    function void raise_error(logic [2:0] code);
      put(EV_ERR, NO_KIND, CH_ZERO, code);
      mode = M_DROP;
    endfunction

    function void start_token(logic [7:0] c);
      mode = M_IDLE;
      if (blank_ch(c)) return;
      if (word_head(c)) begin
        any_token = 1'b1;
        put(EV_BEGIN, K_WORD, CH_ZERO, NO_ERR);
        put(EV_CHAR, K_WORD, c, NO_ERR);
        mode = M_WORD;
      end else if (digit_ch(c)) begin
        any_token = 1'b1;
        put(EV_BEGIN, K_NUM, CH_ZERO, NO_ERR);
        put(EV_CHAR, K_NUM, c, NO_ERR);
        mode = M_NUM;
      end else if (c == CH_MINUS) begin
        mode = M_MINUS;
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        any_token = 1'b1;
        dquote = (c == CH_DQUOTE);
        put(EV_BEGIN, K_STR, CH_ZERO, NO_ERR);
        mode = M_STR;
      end else if (symbol_ch(c)) begin
        any_token = 1'b1;
        put(EV_BEGIN, K_SYM, CH_ZERO, NO_ERR);
        put(EV_CHAR, K_SYM, c, NO_ERR);
        put(EV_END, K_SYM, CH_ZERO, NO_ERR);
      end else begin
        raise_error(ERR_BAD_CHAR);
      end
    endfunction

    function void close_command();
      case (mode)
        M_WORD: begin
          put(EV_END, K_WORD, CH_ZERO, NO_ERR);
          mode = M_IDLE;
        end
        M_NUM: begin
          put(EV_END, K_NUM, CH_ZERO, NO_ERR);
          mode = M_IDLE;
        end
        M_STR: raise_error(ERR_UNCLOSED);
        M_ESC: raise_error(ERR_INCOMPLETE);
        M_IDLE: ;
        default: raise_error(ERR_BAD_CHAR);
      endcase
      if (mode == M_IDLE) begin
        if (any_token) put(EV_CMD, NO_KIND, CH_ZERO, NO_ERR);
        else raise_error(ERR_EMPTY);
      end
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      logic [7:0] quote;
      logic [7:0] plain;
      bit         known;
      burst.delete();
      case (mode)
        M_MARK0: if (c == CH_MARK0) mode = M_MARK1; else start_token(c);
        M_MARK1: if (c == CH_MARK1) mode = M_MARK2; else raise_error(ERR_BAD_CHAR);
        M_MARK2: if (c == CH_MARK2) mode = M_IDLE; else raise_error(ERR_BAD_CHAR);
        M_IDLE: start_token(c);
        M_WORD: begin
          if (word_tail(c)) begin
            put(EV_CHAR, K_WORD, c, NO_ERR);
          end else begin
            put(EV_END, K_WORD, CH_ZERO, NO_ERR);
            start_token(c);
          end
        end
        M_NUM: begin
          if (digit_ch(c)) begin
            put(EV_CHAR, K_NUM, c, NO_ERR);
          end else begin
            put(EV_END, K_NUM, CH_ZERO, NO_ERR);
            start_token(c);
          end
        end
        M_MINUS: begin
          if (digit_ch(c)) begin
            any_token = 1'b1;
            put(EV_BEGIN, K_NUM, CH_ZERO, NO_ERR);
            put(EV_CHAR, K_NUM, CH_MINUS, NO_ERR);
            put(EV_CHAR, K_NUM, c, NO_ERR);
            mode = M_NUM;
          end else begin
            raise_error(ERR_BAD_CHAR);
          end
        end
        M_STR: begin
          quote = dquote ? CH_DQUOTE : CH_SQUOTE;
          if (c == quote) begin
            put(EV_END, K_STR, CH_ZERO, NO_ERR);
            mode = M_IDLE;
          end else if (c == CH_BSLASH) begin
            mode = M_ESC;
          end else begin
            put(EV_CHAR, K_STR, c, NO_ERR);
          end
        end
        M_ESC: begin
          known = 1'b1;
          case (c)
            CH_LOW_N: plain = CH_LF;
            CH_LOW_R: plain = CH_CR;
            CH_LOW_T: plain = CH_TAB;
            CH_BSLASH, CH_SQUOTE, CH_DQUOTE: plain = c;
            default: begin
              known = 1'b0;
              plain = CH_ZERO;
            end
          endcase
          if (known) begin
            put(EV_CHAR, K_STR, plain, NO_ERR);
            mode = M_STR;
          end else begin
            raise_error(ERR_UNSUPP);
          end
        end
        default: mode = M_DROP;
      endcase
      // The final byte closes whatever is open and rearms for the next command,
      // unless an error has already silenced the command.
      if (last) begin
        if (mode != M_DROP) close_command();
        mode      = M_MARK0;
        dquote    = 1'b0;
        any_token = 1'b0;
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) waiting.insert(waiting.size(), burst[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_event(token_event_t got);
      token_event_t want;
      if (waiting.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual ev=%0d kind=%0d char=%02h",
                 $time, got.ev, got.kind, got.ch);
        $display("%0t: unexpected event continued, err=%0d last=%0b",
                 $time, got.err, got.last);
        failures++;
        return;
      end
      want = waiting.pop_front();
      compare_field("event", 8'(want.ev), 8'(got.ev));
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("char", want.ch, got.ch);
      compare_field("error code", 8'(want.err), 8'(got.err));
      compare_field("last flag", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  stt_in_if  in_ch();
  stt_out_if out_ch();

  shell_command_tokenizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  token_event_tracker tracker = new();

  // Bytes of the command being built, sent in order with the last flag on the final one.
  logic [7:0] text_q[$];
  int         bytes_sent;
  // With calm set there are no random idles; hold_off_req asks the receiver for a long stall.
  bit         calm;
  bit         hold_off_req;

  localparam logic [7:0] PUNCT [10] = '{".", "(", ")", "{", "}", "[", "]", ",", ":", ";"};
  localparam logic [7:0] ESCAPES [6] = '{CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_BSLASH, CH_SQUOTE,
                                         CH_DQUOTE};

  always #2 clk = ~clk;

  // The run is bounded in time whatever happens to the handshakes.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_shell_command_tokenizer_core failed");
    $finish;
  end

  // Receiver: ready changes only at the falling edge. When a hold-off is requested it keeps
  // ready low long enough that the internal queue fills and the input channel has to stall.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: every result transaction is checked at the rising edge at which it completes.
  initial begin
    token_event_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.ev   = out_ch.event_res;
        got.kind = out_ch.token_kind;
        got.ch   = out_ch.token_char;
        got.err  = out_ch.error_code;
        got.last = out_ch.last_of_run;
        tracker.check_event(got);
      end
    end
  end

  // Offers one byte and waits for its transaction. Unless calm is set, random idle cycles come
  // first, so that gaps land in every phase of the scanner's work.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.char_byte      <= c;
    in_ch.end_of_command <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_byte(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_command();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic add_mark();
    append_byte(CH_MARK0);
    append_byte(CH_MARK1);
    append_byte(CH_MARK2);
  endtask

  task automatic add_separator();
    if ($urandom_range(1)) append_byte(" ");
    else append_byte(8'($urandom_range(9, 13)));
  endtask

  task automatic add_word_char(input bit head);
    int pick;
    pick = $urandom_range(head ? 53 : 63);
    if (pick < 26) append_byte(8'("A" + pick));
    else if (pick < 52) append_byte(8'("a" + pick - 26));
    else if (pick == 52) append_byte("_");
    else if (pick == 53) append_byte("$");
    else append_byte(8'("0" + pick - 54));
  endtask

  // A token with random content: word, number (perhaps negative), quoted string with escapes
  // (some of them unsupported), or a punctuation symbol.
  task automatic add_token();
    logic [7:0] quote;
    int         n;
    case ($urandom_range(3))
      0: begin
        add_word_char(1'b1);
        repeat ($urandom_range(4)) add_word_char(1'b0);
      end
      1: begin
        if ($urandom_range(3) == 0) append_byte(CH_MINUS);
        repeat ($urandom_range(1, 3)) append_byte(8'("0" + $urandom_range(9)));
      end
      2: begin
        quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        append_byte(quote);
        n = $urandom_range(4);
        repeat (n) begin
          if ($urandom_range(4) == 0) begin
            append_byte(CH_BSLASH);
            if ($urandom_range(7) == 0) append_byte(8'("a" + $urandom_range(12)));
            else append_byte(ESCAPES[$urandom_range(5)]);
          end else begin
            append_byte(8'($urandom_range(255)));
          end
        end
        append_byte(quote);
      end
      default: append_byte(PUNCT[$urandom_range(9)]);
    endcase
  endtask

  // Mostly well-formed commands; the rest are cut short or corrupted, pure noise, or blank.
  task automatic build_random_command();
    int pick;
    int keep;
    pick = $urandom_range(19);
    if (pick < 17) begin
      if ($urandom_range(4) == 0) add_mark();
      repeat ($urandom_range(1, 5)) begin
        add_token();
        if ($urandom_range(2) != 0) add_separator();
      end
      if (pick >= 14) begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) void'(text_q.pop_back());
        if ($urandom_range(1)) text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
    end else if (pick < 19) begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3)) add_separator();
    end
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int random_start;
    int rel;
    bit hold_started;
    bit pause_done;

    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.char_byte      = CH_ZERO;
    in_ch.end_of_command = 1'b0;
    bytes_sent           = 0;
    calm                 = 1'b0;
    hold_off_req         = 1'b0;
    hold_started         = 1'b0;
    pause_done           = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed commands. A full mark then a word closed by the final byte.
    add_mark();
    add_text("Z");
    send_command();
    // A mark broken after its first byte; the rest of the command is dropped.
    append_byte(CH_MARK0);
    add_text("A1");
    send_command();
    // Nothing but the mark: an empty command.
    add_mark();
    send_command();
    // A negative number, then a lone minus cut by the end of the command.
    add_text("-7 -");
    send_command();
    // A supported escape followed by an unsupported one.
    add_text("\"\\t\\z");
    send_command();
    // A byte above the ASCII range on its own.
    append_byte(8'hFF);
    send_command();
    // A backslash as the final byte, then a string left open.
    add_text("'\\");
    send_command();
    add_text("'x");
    send_command();
    // A single symbol makes a complete command.
    add_text("(");
    send_command();

    // Random commands, with a long calm stretch in which the receiver stalls for a while,
    // and later one pause until every owed event has come out.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_ITEMS) begin
      rel  = bytes_sent - random_start;
      calm = (rel >= 50 && rel < 130);
      if (!hold_started && rel >= 70) begin
        hold_off_req = 1'b1;
        hold_started = 1'b1;
      end
      if (!pause_done && rel >= 170) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        pause_done = 1'b1;
      end
      build_random_command();
      send_command();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("tb_shell_command_tokenizer_core passed");
    end else begin
      $display("tb_shell_command_tokenizer_core failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/stt_pkg.sv
src/stt_if.sv
src/stt_front.sv
src/stt_queue.sv
src/stt_back.sv
src/shell_command_tokenizer_core.sv
tb/tb_shell_command_tokenizer_core.sv
